// ----- sv/rsmh_pkg.sv -----
package rsmh_pkg;

  localparam int NUM_SENSORS_DEF     = 2;
  localparam int WINDOW_DEPTH_DEF    = 5;
  localparam int SPIKE_CONFIRM_DEF   = 3;
  localparam int FAULT_STREAK_DEF    = 10;
  localparam int DEGRADED_STREAK_DEF = 3;
  localparam int REQUIRE_ALL_DEF     = 1;

  localparam int DistW    = 14;
  localparam int TimeW    = 32;
  localparam int StreakW  = 16;
  localparam int RunW     = 8;
  localparam int CountW   = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegStop      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegClear     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWarn      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxJump   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStale     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinGood   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegObsConf   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegClearConf = 3'd7;

  localparam logic [1:0] HealthOk       = 2'd0;
  localparam logic [1:0] HealthDegraded = 2'd1;
  localparam logic [1:0] HealthFault    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATE,
    ST_SCAN,
    ST_MED,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic gate;
    logic scan_clr;
    logic scan;
    logic median;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic [DistW-1:0]   stop_distance;
    logic [DistW-1:0]   clear_distance;
    logic [DistW-1:0]   warn_distance;
    logic [DistW-1:0]   max_jump;
    logic [15:0]        stale_time_ms;
    logic [CountW-1:0]  min_good_samples;
    logic [RunW-1:0]    obstacle_confirm;
    logic [RunW-1:0]    clear_confirm;
  } cfg_t;

  typedef struct packed {
    logic               sensor_index;
    logic [DistW-1:0]   raw_distance;
    logic [TimeW-1:0]   now_ms;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0]   filtered_distance;
    logic               sensor_valid;
    logic [CountW-1:0]  good_count;
    logic               sensor_obstacle;
    logic               sensor_warning;
    logic [StreakW-1:0] timeout_streak;
    logic [1:0]         health;
    logic               any_obstacle;
    logic               any_warning;
    logic               sensor_fault;
    logic               forward_blocked;
  } out_t;

endpackage

// ----- sv/rsmh_stream_if.sv -----
interface rsmh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/rsmh_ctrl.sv -----
module rsmh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsmh_pkg::status_t status_i,
  output rsmh_pkg::cmd_t    cmd_o
);

  rsmh_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsmh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsmh_pkg::ST_IDLE:   if (in_valid_i) state_d = rsmh_pkg::ST_GATE;
      rsmh_pkg::ST_GATE:   state_d = rsmh_pkg::ST_SCAN;
      rsmh_pkg::ST_SCAN:   if (status_i.scan_done) state_d = rsmh_pkg::ST_MED;
      rsmh_pkg::ST_MED:    state_d = rsmh_pkg::ST_UPDATE;
      rsmh_pkg::ST_UPDATE: state_d = rsmh_pkg::ST_OUT;
      rsmh_pkg::ST_OUT:    if (!status_i.out_busy) state_d = rsmh_pkg::ST_IDLE;
      default:             state_d = rsmh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rsmh_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rsmh_pkg::ST_GATE: begin
        cmd_o.gate     = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      rsmh_pkg::ST_SCAN:   cmd_o.scan = 1'b1;
      rsmh_pkg::ST_MED:    cmd_o.median = 1'b1;
      rsmh_pkg::ST_UPDATE: cmd_o.update = 1'b1;
      rsmh_pkg::ST_OUT:    cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

// ----- sv/rsmh_datapath.sv -----
module rsmh_datapath #(
  parameter int NUM_SENSORS     = rsmh_pkg::NUM_SENSORS_DEF,
  parameter int WINDOW_DEPTH    = rsmh_pkg::WINDOW_DEPTH_DEF,
  parameter int SPIKE_CONFIRM   = rsmh_pkg::SPIKE_CONFIRM_DEF,
  parameter int FAULT_STREAK    = rsmh_pkg::FAULT_STREAK_DEF,
  parameter int DEGRADED_STREAK = rsmh_pkg::DEGRADED_STREAK_DEF,
  parameter int REQUIRE_ALL     = rsmh_pkg::REQUIRE_ALL_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsmh_pkg::cfg_t    cfg_i,
  input  rsmh_pkg::in_t     in_i,
  input  rsmh_pkg::cmd_t    cmd_i,
  output rsmh_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rsmh_pkg::out_t    out_o
);

  localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int DW = rsmh_pkg::DistW;
  localparam int RW = rsmh_pkg::RunW;
  localparam int CW = rsmh_pkg::CountW;
  localparam int HW = rsmh_pkg::StreakW;

  logic [DW-1:0]      win_q   [NUM_SENSORS][WINDOW_DEPTH];
  logic [PW-1:0]      wp_q    [NUM_SENSORS];
  logic [DW-1:0]      filt_q  [NUM_SENSORS];
  logic               valid_q [NUM_SENSORS];
  logic [31:0]        lgt_q   [NUM_SENSORS];
  logic [CW-1:0]      good_q  [NUM_SENSORS];
  logic [RW-1:0]      spike_q [NUM_SENSORS];
  logic [RW-1:0]      near_q  [NUM_SENSORS];
  logic [RW-1:0]      far_q   [NUM_SENSORS];
  logic               obs_q   [NUM_SENSORS];
  logic               warn_q  [NUM_SENSORS];
  logic [HW-1:0]      strk_q  [NUM_SENSORS];

  rsmh_pkg::in_t      item_q;
  logic               hit_q;
  logic [SW-1:0]      s_q;
  logic [DW-1:0]      cur_q   [WINDOW_DEPTH];
  logic [CW-1:0]      rank_q  [WINDOW_DEPTH];
  logic [CW-1:0]      i_q;
  logic [DW:0]        msum_q;
  logic               out_valid_q;
  rsmh_pkg::out_t     out_q;

  logic [CW-1:0]      good_w;
  logic [CW-1:0]      lo_pos, hi_pos;
  logic [DW-1:0]      lo_v, hi_v;
  logic [DW-1:0]      pivot;
  logic               fresh_w;
  logic [31:0]        age_w;

  // Rank each good entry: count of entries that sort before it (ties by slot).
  assign pivot = cur_q[i_q[PW-1:0]];
  assign status_o.scan_done = (i_q == CW'(WINDOW_DEPTH - 1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    good_w = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      good_w = good_w + CW'(cur_q[k] != '0);
    end
    lo_pos = CW'((good_w - CW'(1)) >> 1);
    hi_pos = CW'(good_w >> 1);
    lo_v = '0;
    hi_v = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (cur_q[k] != '0 && rank_q[k] == lo_pos) lo_v = cur_q[k];
      if (cur_q[k] != '0 && rank_q[k] == hi_pos) hi_v = cur_q[k];
    end
  end

  assign age_w   = item_q.now_ms - lgt_q[s_q];
  assign fresh_w = age_w <= 32'(cfg_i.stale_time_ms);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_i;
      s_q    <= SW'(in_i.sensor_index);
    end
    if (cmd_i.median) begin
      msum_q <= (DW+1)'(lo_v) + (DW+1)'(hi_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        for (int k = 0; k < WINDOW_DEPTH; k++) win_q[s][k] <= '0;
        wp_q[s]    <= '0;
        filt_q[s]  <= '0;
        valid_q[s] <= 1'b0;
        lgt_q[s]   <= '0;
        good_q[s]  <= '0;
        spike_q[s] <= '0;
        near_q[s]  <= '0;
        far_q[s]   <= '0;
        obs_q[s]   <= 1'b0;
        warn_q[s]  <= 1'b0;
        strk_q[s]  <= '0;
      end
      hit_q       <= 1'b0;
      i_q         <= '0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        cur_q[k]  <= '0;
        rank_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_i.out_load) out_valid_q <= 1'b0;
      if (cmd_i.load) begin
        hit_q <= 32'(in_i.sensor_index) < 32'(NUM_SENSORS);
      end
      if (cmd_i.gate) begin : gate_blk
        logic          acc;
        logic [DW-1:0] f;
        logic [RW-1:0] sp;
        f  = filt_q[s_q];
        acc = 1'b1;
        sp  = '0;
        if (item_q.raw_distance != '0 && valid_q[s_q] && f != '0 &&
            item_q.raw_distance > f &&
            (item_q.raw_distance - f) > cfg_i.max_jump) begin
          sp = spike_q[s_q] + RW'(1);
          if (32'(sp) < SPIKE_CONFIRM) acc = 1'b0;
          else sp = '0;
        end
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
          cur_q[k] <= (hit_q && acc && PW'(k) == wp_q[s_q]) ? item_q.raw_distance
                                                            : win_q[s_q][k];
        end
        if (hit_q) begin
          if (item_q.raw_distance != '0) strk_q[s_q] <= '0;
          else if (strk_q[s_q] != '1) strk_q[s_q] <= strk_q[s_q] + HW'(1);
          spike_q[s_q] <= sp;
          if (acc) begin
            win_q[s_q][wp_q[s_q]] <= item_q.raw_distance;
            wp_q[s_q] <= (32'(wp_q[s_q]) == WINDOW_DEPTH - 1) ? '0
                                                            : wp_q[s_q] + PW'(1);
            if (item_q.raw_distance != '0) lgt_q[s_q] <= item_q.now_ms;
          end
        end
      end
      if (cmd_i.scan_clr) begin
        i_q <= '0;
      end
      if (cmd_i.scan) begin
        begin : rank_blk
          logic [CW-1:0] c;
          c = '0;
          for (int k = 0; k < WINDOW_DEPTH; k++) begin
            if (cur_q[k] != '0 && (cur_q[k] < pivot ||
                (cur_q[k] == pivot && CW'(k) < i_q))) c = c + CW'(1);
          end
          rank_q[i_q[PW-1:0]] <= c;
        end
        if (!status_o.scan_done) i_q <= i_q + CW'(1);
      end
      if (cmd_i.update && hit_q) begin : upd_blk
        logic          v;
        logic [DW-1:0] f;
        logic [RW-1:0] nr, fr;
        logic          ob;
        v  = (good_w >= cfg_i.min_good_samples) && good_w != '0 && fresh_w;
        f  = filt_q[s_q];
        if (v) f = msum_q[DW:1];
        else if (!fresh_w) f = '0;
        nr = near_q[s_q];
        fr = far_q[s_q];
        ob = obs_q[s_q];
        good_q[s_q]  <= good_w;
        valid_q[s_q] <= v;
        filt_q[s_q]  <= f;
        if (!v || f == '0) begin
          near_q[s_q] <= '0;
          far_q[s_q]  <= '0;
          warn_q[s_q] <= 1'b0;
        end else begin
          if (f <= cfg_i.stop_distance) begin
            fr = '0;
            if (nr != '1) nr = nr + RW'(1);
          end else if (f >= cfg_i.clear_distance) begin
            nr = '0;
            if (fr != '1) fr = fr + RW'(1);
          end else begin
            nr = '0;
            fr = '0;
          end
          if (nr >= cfg_i.obstacle_confirm) ob = 1'b1;
          else if (fr >= cfg_i.clear_confirm) ob = 1'b0;
          near_q[s_q] <= nr;
          far_q[s_q]  <= fr;
          obs_q[s_q]  <= ob;
          warn_q[s_q] <= f <= cfg_i.warn_distance;
        end
      end
      if (cmd_i.out_load) begin : out_blk
        logic any_o, any_w, all_v, one_v;
        any_o = 1'b0;
        any_w = 1'b0;
        all_v = 1'b1;
        one_v = 1'b0;
        for (int s = 0; s < NUM_SENSORS; s++) begin
          any_o = any_o | obs_q[s];
          any_w = any_w | warn_q[s];
          one_v = one_v | valid_q[s];
          all_v = all_v & valid_q[s];
        end
        out_valid_q         <= 1'b1;
        out_q.any_obstacle  <= any_o;
        out_q.any_warning   <= any_w;
        out_q.sensor_fault  <= (REQUIRE_ALL != 0) ? !all_v : !one_v;
        out_q.forward_blocked <= any_o | ((REQUIRE_ALL != 0) ? !all_v : !one_v);
        if (hit_q) begin
          out_q.filtered_distance <= filt_q[s_q];
          out_q.sensor_valid      <= valid_q[s_q];
          out_q.good_count        <= good_q[s_q];
          out_q.sensor_obstacle   <= obs_q[s_q];
          out_q.sensor_warning    <= warn_q[s_q];
          out_q.timeout_streak    <= strk_q[s_q];
          if (!fresh_w || good_q[s_q] == '0 || 32'(strk_q[s_q]) >= FAULT_STREAK)
            out_q.health <= rsmh_pkg::HealthFault;
          else if (32'(good_q[s_q]) < WINDOW_DEPTH ||
                   32'(strk_q[s_q]) >= DEGRADED_STREAK || !valid_q[s_q])
            out_q.health <= rsmh_pkg::HealthDegraded;
          else
            out_q.health <= rsmh_pkg::HealthOk;
        end else begin
          out_q.filtered_distance <= '0;
          out_q.sensor_valid      <= 1'b0;
          out_q.good_count        <= '0;
          out_q.sensor_obstacle   <= 1'b0;
          out_q.sensor_warning    <= 1'b0;
          out_q.timeout_streak    <= '0;
          out_q.health            <= rsmh_pkg::HealthFault;
        end
      end
    end
  end

endmodule

// ----- sv/range_sensor_median_hysteresis_latch.sv -----
// Channel   Modport  Payload
// in_if     sink     sensor_index, raw_distance, now_ms
// out_if    source   filtered_distance ... forward_blocked (one per transaction)
// cfg       write    cfg_we_i, cfg_idx_i, cfg_data_i
//
// A transaction passes the gate, scan, median, update and output states between
// one accept and the next; the rank scan places one window entry per cycle with
// a shared comparator row, and the result is registered in the output state.
// Reset clears all sensor state at once; no clearing pass.
// A stalled output holds the controller in its output state until taken.
module range_sensor_median_hysteresis_latch #(
  parameter int NUM_SENSORS     = rsmh_pkg::NUM_SENSORS_DEF,
  parameter int WINDOW_DEPTH    = rsmh_pkg::WINDOW_DEPTH_DEF,
  parameter int SPIKE_CONFIRM   = rsmh_pkg::SPIKE_CONFIRM_DEF,
  parameter int FAULT_STREAK    = rsmh_pkg::FAULT_STREAK_DEF,
  parameter int DEGRADED_STREAK = rsmh_pkg::DEGRADED_STREAK_DEF,
  parameter int REQUIRE_ALL     = rsmh_pkg::REQUIRE_ALL_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rsmh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rsmh_pkg::CfgDataW-1:0]  cfg_data_i,
  rsmh_stream_if.sink                    in_if,
  rsmh_stream_if.source                  out_if
);

  rsmh_pkg::cfg_t    cfg_q;
  rsmh_pkg::cmd_t    cmd;
  rsmh_pkg::status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_distance    <= 14'd640;
      cfg_q.clear_distance   <= 14'd1040;
      cfg_q.warn_distance    <= 14'd1440;
      cfg_q.max_jump         <= 14'd480;
      cfg_q.stale_time_ms    <= 16'd500;
      cfg_q.min_good_samples <= 4'd3;
      cfg_q.obstacle_confirm <= 8'd2;
      cfg_q.clear_confirm    <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsmh_pkg::RegStop:      cfg_q.stop_distance    <= cfg_data_i[13:0];
        rsmh_pkg::RegClear:     cfg_q.clear_distance   <= cfg_data_i[13:0];
        rsmh_pkg::RegWarn:      cfg_q.warn_distance    <= cfg_data_i[13:0];
        rsmh_pkg::RegMaxJump:   cfg_q.max_jump         <= cfg_data_i[13:0];
        rsmh_pkg::RegStale:     cfg_q.stale_time_ms    <= cfg_data_i;
        rsmh_pkg::RegMinGood:   cfg_q.min_good_samples <= cfg_data_i[3:0];
        rsmh_pkg::RegObsConf:   cfg_q.obstacle_confirm <= cfg_data_i[7:0];
        rsmh_pkg::RegClearConf: cfg_q.clear_confirm    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  rsmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsmh_datapath #(
    .NUM_SENSORS     (NUM_SENSORS),
    .WINDOW_DEPTH    (WINDOW_DEPTH),
    .SPIKE_CONFIRM   (SPIKE_CONFIRM),
    .FAULT_STREAK    (FAULT_STREAK),
    .DEGRADED_STREAK (DEGRADED_STREAK),
    .REQUIRE_ALL     (REQUIRE_ALL)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_if.payload),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_o       (out_if.payload)
  );

endmodule

// ----- sv/rsmh_checker.sv -----
module rsmh_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic fwd_blocked,
  input logic any_obs,
  input logic fault,
  input logic [1:0] health
);

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> fwd_blocked == (any_obs || fault))
    else $error("blocked flag inconsistent");

  a_health: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> health != 2'd3)
    else $error("bad health code");

endmodule

bind range_sensor_median_hysteresis_latch rsmh_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .fwd_blocked (out_if.payload.forward_blocked),
  .any_obs     (out_if.payload.any_obstacle),
  .fault       (out_if.payload.sensor_fault),
  .health      (out_if.payload.health)
);
